// File: rtl/rtwc_pkg.sv
// Shared types and constants of the textured wall column walker.
package rtwc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_LH,
    ST_MUL_HIT,
    ST_TEX_COL,
    ST_DIV_STEP,
    ST_MUL_POS,
    ST_FINISH
  } seq_state_t;

  typedef struct packed {
    logic div_load_lh;
    logic div_load_step;
    logic div_run;
    logic mul_en;
    logic mul_pos;
    logic lh_en;
    logic tcol_en;
    logic step_en;
    logic finish_en;
  } seq_ctrl_t;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  localparam logic SIDE_VERTICAL = 1'b0;

  localparam logic [1:0] FACE_NORTH = 2'd0;
  localparam logic [1:0] FACE_SOUTH = 2'd1;
  localparam logic [1:0] FACE_WEST  = 2'd2;
  localparam logic [1:0] FACE_EAST  = 2'd3;

  localparam logic [3:0] TEX_LOG2_MIN   = 4'd1;
  localparam logic [3:0] TEX_LOG2_MAX   = 4'd10;
  localparam logic [3:0] TEX_LOG2_RESET = 4'd6;

  localparam int         REG_ADDR_W        = 3;
  localparam logic [0:0] REG_TEX_SIZE_LOG2 = 1'b0;

  localparam logic [15:0] LH_MAX = 16'hFFFF;

endpackage

// File: rtl/raycast_textured_wall_column.sv
// Top level of the textured wall column walker: column setup sequencer and pixel walk.
//
// A start word (action 0) sets up one screen column: the wall height is found as
// SCREEN_H*2^16 divided by the wall distance, the row span is clamped to the screen,
// the texel column is taken from the fractional hit point, and the Q16 texture step
// (texture size*2^16 divided by the wall height) and start position are prepared.
// Setup runs on one shared restoring divider, which yields one quotient bit a cycle,
// and one shared multiplier. The divider quotient is DIV_W bits wide, where DIV_W is
// the larger of 27 and clog2(SCREEN_H+1)+16; in_ready stays low while setup runs. A
// step word (action 1) yields one pixel word on the result channel, so pixel words
// flow at one per cycle while the consumer keeps up; the result register lets a new
// word in while the previous pixel is taken in the same cycle. A step word yields
// nothing when the column is finished, lies beyond SCREEN_W, has an empty row span
// or an undetermined face; a start word never yields a result. The texture size
// register is written over the APB port and should only change while the block is
// idle.
module raycast_textured_wall_column
  import rtwc_pkg::*;
#(
  parameter int SCREEN_H = 512,
  parameter int SCREEN_W = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_action,
  input  logic [11:0]           in_column,
  input  logic [25:0]           in_pos_x,
  input  logic [25:0]           in_pos_y,
  input  logic signed [15:0]    in_ray_dir_x,
  input  logic signed [15:0]    in_ray_dir_y,
  input  logic [25:0]           in_wall_dist,
  input  logic                  in_hit_side,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [11:0]           out_pixel_x,
  output logic [11:0]           out_pixel_y,
  output logic [1:0]            out_face,
  output logic [9:0]            out_tex_col,
  output logic [9:0]            out_tex_row,
  output logic                  out_last,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // The divider handles both the wall height division (numerator SCREEN_H*2^16) and
  // the texture step division (numerator up to 1024*2^16, 27 bits).
  localparam int NUM_W  = $clog2(SCREEN_H + 1) + 16;
  localparam int DIV_W  = (NUM_W > 27) ? NUM_W : 27;
  localparam int CNT_W  = $clog2(DIV_W + 1);

  localparam logic [DIV_W-1:0] LH_NUM = DIV_W'(SCREEN_H) << 16;
  localparam logic [15:0]      SH16   = 16'(SCREEN_H);
  localparam logic [15:0]      HALF_H = 16'(SCREEN_H / 2);
  localparam logic [12:0]      SW13   = 13'(SCREEN_W);

  // Sequencer
  seq_state_t state_r, state_nxt;
  seq_ctrl_t  ctrl;

  // Configuration
  logic [3:0] tex_log2_r, tex_log2_nxt;
  logic [3:0] tex_log2_eff;
  logic [3:0] tex_shift;
  logic [9:0] tex_mask;
  logic       cfg_write;

  // Values captured from the start word
  logic [25:0]        dist_r, dist_nxt;
  logic [25:0]        pos_sel_r, pos_sel_nxt;
  logic signed [15:0] dir_r, dir_nxt;
  logic               face_ok_r, face_ok_nxt;
  logic               mirror_r, mirror_nxt;
  logic               col_ok_r, col_ok_nxt;

  // Shared divider
  logic [DIV_W-1:0] div_q_r, div_q_nxt;
  logic [25:0]      div_rem_r, div_rem_nxt;
  logic [25:0]      div_den_r, div_den_nxt;
  logic [CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [26:0]      div_shifted;
  logic [27:0]      div_trial;
  logic             div_done;

  // Shared multiplier
  logic signed [26:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [43:0] mul_p;
  logic [29:0]        mul_r, mul_nxt;

  // Column setup intermediates
  logic [15:0] lh_r, lh_nxt;
  logic [15:0] half16;
  logic [15:0] offset;
  logic [25:0] step_val;
  logic [29:0] frac30;
  logic [9:0]  tcol_raw;
  logic [15:0] row_start;
  logic [15:0] row_end_full;
  logic [15:0] row_end;

  // Column state
  logic [11:0] cur_row_r, cur_row_nxt;
  logic [11:0] end_row_r, end_row_nxt;
  logic [25:0] tex_pos_r, tex_pos_nxt;
  logic [25:0] tex_step_r, tex_step_nxt;
  logic [9:0]  held_tex_col_r, held_tex_col_nxt;
  logic [1:0]  held_face_r, held_face_nxt;
  logic [11:0] held_column_r, held_column_nxt;
  logic        drawable_r, drawable_nxt;

  // Result register
  logic        out_valid_r, out_valid_nxt;
  logic [11:0] out_pixel_x_r, out_pixel_x_nxt;
  logic [11:0] out_pixel_y_r, out_pixel_y_nxt;
  logic [1:0]  out_face_r, out_face_nxt;
  logic [9:0]  out_tex_col_r, out_tex_col_nxt;
  logic [9:0]  out_tex_row_r, out_tex_row_nxt;
  logic        out_last_r, out_last_nxt;

  logic in_fire;
  logic start_fire;
  logic step_fire;
  logic pixel_last;

  // ---------------------------------------------------------------------------
  // Handshakes. Words are only taken in idle, and only when the result register is
  // free or is being emptied in this same cycle.
  // ---------------------------------------------------------------------------
  assign in_ready   = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_fire    = in_valid && in_ready;
  assign start_fire = in_fire && (in_action == ACT_START);
  assign step_fire  = in_fire && (in_action == ACT_STEP) && drawable_r;

  // ---------------------------------------------------------------------------
  // Configuration port. One register; the out-of-range codes are clamped on use.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_TEX_SIZE_LOG2);
  assign prdata    = (paddr[2] == REG_TEX_SIZE_LOG2) ? {28'd0, tex_log2_r} : 32'd0;

  always_comb begin
    tex_log2_nxt = cfg_write ? pwdata[3:0] : tex_log2_r;
  end

  always_comb begin
    if (tex_log2_r < TEX_LOG2_MIN) begin
      tex_log2_eff = TEX_LOG2_MIN;
    end else if (tex_log2_r > TEX_LOG2_MAX) begin
      tex_log2_eff = TEX_LOG2_MAX;
    end else begin
      tex_log2_eff = tex_log2_r;
    end
  end

  // Texture size T = 2^lg; the texel row and column masks are T-1.
  assign tex_shift = TEX_LOG2_MAX - tex_log2_eff;
  assign tex_mask  = 10'h3FF >> tex_shift;

  // ---------------------------------------------------------------------------
  // Sequencer: next state.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start_fire) state_nxt = ST_DIV_LH;
      end
      ST_DIV_LH: begin
        if (div_done) state_nxt = ST_MUL_HIT;
      end
      ST_MUL_HIT:  state_nxt = ST_TEX_COL;
      ST_TEX_COL:  state_nxt = ST_DIV_STEP;
      ST_DIV_STEP: begin
        if (div_done) state_nxt = ST_MUL_POS;
      end
      ST_MUL_POS:  state_nxt = ST_FINISH;
      ST_FINISH:   state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer: control outputs.
  always_comb begin
    ctrl = '0;
    case (state_r)
      ST_IDLE:     ctrl.div_load_lh = start_fire;
      ST_DIV_LH:   ctrl.div_run = 1'b1;
      ST_MUL_HIT: begin
        ctrl.mul_en = 1'b1;
        ctrl.lh_en  = 1'b1;
      end
      ST_TEX_COL: begin
        ctrl.tcol_en       = 1'b1;
        ctrl.div_load_step = 1'b1;
      end
      ST_DIV_STEP: ctrl.div_run = 1'b1;
      ST_MUL_POS: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_pos = 1'b1;
        ctrl.step_en = 1'b1;
      end
      ST_FINISH:   ctrl.finish_en = 1'b1;
      default:     ctrl = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Start word capture. The hit coordinate along the wall is y for a vertical grid
  // line and x for a horizontal one; the other direction component picks the face.
  // ---------------------------------------------------------------------------
  always_comb begin
    dist_nxt        = dist_r;
    pos_sel_nxt     = pos_sel_r;
    dir_nxt         = dir_r;
    face_ok_nxt     = face_ok_r;
    mirror_nxt      = mirror_r;
    col_ok_nxt      = col_ok_r;
    held_face_nxt   = held_face_r;
    held_column_nxt = held_column_r;
    if (start_fire) begin
      dist_nxt        = in_wall_dist;
      held_column_nxt = in_column;
      col_ok_nxt      = {1'b0, in_column} < SW13;
      if (in_hit_side == SIDE_VERTICAL) begin
        pos_sel_nxt   = in_pos_y;
        dir_nxt       = in_ray_dir_y;
        face_ok_nxt   = (in_ray_dir_x != 16'sd0);
        held_face_nxt = in_ray_dir_x[15] ? FACE_WEST : FACE_EAST;
        mirror_nxt    = !in_ray_dir_x[15] && (in_ray_dir_x != 16'sd0);
      end else begin
        pos_sel_nxt   = in_pos_x;
        dir_nxt       = in_ray_dir_x;
        face_ok_nxt   = (in_ray_dir_y != 16'sd0);
        held_face_nxt = (!in_ray_dir_y[15] && (in_ray_dir_y != 16'sd0)) ?
                        FACE_NORTH : FACE_SOUTH;
        mirror_nxt    = in_ray_dir_y[15];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared restoring divider: one quotient bit per cycle. The dividend shifts out of
  // the top of div_q_r while quotient bits shift in at the bottom. A zero divisor
  // gives an all-ones quotient, which saturates the wall height as required.
  // ---------------------------------------------------------------------------
  assign div_shifted = {div_rem_r, div_q_r[DIV_W-1]};
  assign div_trial   = {1'b0, div_shifted} - {2'b00, div_den_r};
  assign div_done    = (div_cnt_r == CNT_W'(1));

  always_comb begin
    div_q_nxt   = div_q_r;
    div_rem_nxt = div_rem_r;
    div_den_nxt = div_den_r;
    div_cnt_nxt = div_cnt_r;
    if (ctrl.div_load_lh) begin
      div_q_nxt   = LH_NUM;
      div_rem_nxt = '0;
      div_den_nxt = in_wall_dist;
      div_cnt_nxt = CNT_W'(DIV_W);
    end else if (ctrl.div_load_step) begin
      div_q_nxt   = DIV_W'(1) << (5'd16 + {1'b0, tex_log2_eff});
      div_rem_nxt = '0;
      div_den_nxt = {10'd0, lh_r};
      div_cnt_nxt = CNT_W'(DIV_W);
    end else if (ctrl.div_run) begin
      div_q_nxt   = {div_q_r[DIV_W-2:0], !div_trial[27]};
      div_rem_nxt = div_trial[27] ? div_shifted[25:0] : div_trial[25:0];
      div_cnt_nxt = div_cnt_r - CNT_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Wall height and the derived quantities. Only bits 25:16 of the texture position
  // ever reach a result, so position and step are kept modulo 2^26.
  // ---------------------------------------------------------------------------
  always_comb begin
    lh_nxt = lh_r;
    if (ctrl.lh_en) begin
      lh_nxt = (|div_q_r[DIV_W-1:16]) ? LH_MAX : div_q_r[15:0];
    end
  end

  assign half16   = {1'b0, lh_r[15:1]};
  assign offset   = (half16 >= HALF_H) ? (half16 - HALF_H) : 16'd0;
  assign step_val = (lh_r == 16'd0) ? 26'd0 : div_q_r[25:0];

  assign row_start    = (half16 >= HALF_H) ? 16'd0 : (HALF_H - half16);
  assign row_end_full = half16 + HALF_H;
  assign row_end      = (row_end_full > SH16) ? SH16 : row_end_full;

  // ---------------------------------------------------------------------------
  // Shared multiplier: distance times direction for the hit point, then the row
  // offset times the step for the starting texture position.
  // ---------------------------------------------------------------------------
  assign mul_a = ctrl.mul_pos ? $signed({1'b0, step_val}) : $signed({1'b0, dist_r});
  assign mul_b = ctrl.mul_pos ? $signed({1'b0, offset}) : $signed({dir_r[15], dir_r});
  assign mul_p = mul_a * mul_b;

  always_comb begin
    mul_nxt = ctrl.mul_en ? mul_p[29:0] : mul_r;
  end

  // Fractional part of the hit point in Q.30 and its top lg bits as the texel column.
  assign frac30   = {pos_sel_r[15:0], 14'd0} + mul_r;
  assign tcol_raw = frac30[29:20] >> tex_shift;

  always_comb begin
    held_tex_col_nxt = held_tex_col_r;
    if (ctrl.tcol_en) begin
      held_tex_col_nxt = mirror_r ? (tcol_raw ^ tex_mask) : tcol_raw;
    end
  end

  // ---------------------------------------------------------------------------
  // Column state and the pixel walk.
  // ---------------------------------------------------------------------------
  assign pixel_last = (cur_row_r == end_row_r);

  always_comb begin
    cur_row_nxt  = cur_row_r;
    end_row_nxt  = end_row_r;
    tex_pos_nxt  = tex_pos_r;
    tex_step_nxt = tex_step_r;
    drawable_nxt = drawable_r;
    if (ctrl.step_en) begin
      tex_step_nxt = step_val;
    end
    if (ctrl.finish_en) begin
      tex_pos_nxt  = mul_r[25:0];
      cur_row_nxt  = row_start[11:0];
      end_row_nxt  = 12'(row_end - 16'd1);
      drawable_nxt = face_ok_r && col_ok_r && (row_start < row_end);
    end else if (step_fire) begin
      tex_pos_nxt = tex_pos_r + tex_step_r;
      if (pixel_last) begin
        drawable_nxt = 1'b0;
      end else begin
        cur_row_nxt = cur_row_r + 12'd1;
      end
    end
  end

  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_pixel_x_nxt = out_pixel_x_r;
    out_pixel_y_nxt = out_pixel_y_r;
    out_face_nxt    = out_face_r;
    out_tex_col_nxt = out_tex_col_r;
    out_tex_row_nxt = out_tex_row_r;
    out_last_nxt    = out_last_r;
    if (step_fire) begin
      out_valid_nxt   = 1'b1;
      out_pixel_x_nxt = held_column_r;
      out_pixel_y_nxt = cur_row_r;
      out_face_nxt    = held_face_r;
      out_tex_col_nxt = held_tex_col_r;
      out_tex_row_nxt = tex_pos_r[25:16] & tex_mask;
      out_last_nxt    = pixel_last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pixel_x = out_pixel_x_r;
  assign out_pixel_y = out_pixel_y_r;
  assign out_face    = out_face_r;
  assign out_tex_col = out_tex_col_r;
  assign out_tex_row = out_tex_row_r;
  assign out_last    = out_last_r;

  // ---------------------------------------------------------------------------
  // Registers. Control state is reset; the datapath is qualified by it.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tex_log2_r  <= TEX_LOG2_RESET;
      drawable_r  <= 1'b0;
      out_valid_r <= 1'b0;
      div_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      tex_log2_r  <= tex_log2_nxt;
      drawable_r  <= drawable_nxt;
      out_valid_r <= out_valid_nxt;
      div_cnt_r   <= div_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dist_r         <= dist_nxt;
    pos_sel_r      <= pos_sel_nxt;
    dir_r          <= dir_nxt;
    face_ok_r      <= face_ok_nxt;
    mirror_r       <= mirror_nxt;
    col_ok_r       <= col_ok_nxt;
    div_q_r        <= div_q_nxt;
    div_rem_r      <= div_rem_nxt;
    div_den_r      <= div_den_nxt;
    mul_r          <= mul_nxt;
    lh_r           <= lh_nxt;
    cur_row_r      <= cur_row_nxt;
    end_row_r      <= end_row_nxt;
    tex_pos_r      <= tex_pos_nxt;
    tex_step_r     <= tex_step_nxt;
    held_tex_col_r <= held_tex_col_nxt;
    held_face_r    <= held_face_nxt;
    held_column_r  <= held_column_nxt;
    out_pixel_x_r  <= out_pixel_x_nxt;
    out_pixel_y_r  <= out_pixel_y_nxt;
    out_face_r     <= out_face_nxt;
    out_tex_col_r  <= out_tex_col_nxt;
    out_tex_row_r  <= out_tex_row_nxt;
    out_last_r     <= out_last_nxt;
  end

endmodule
